// ----- rtl/core/rpn_stack_calculator_macros.svh -----
// Assertion helpers shared by the calculator RTL.
// Both expect clk and rst_n in scope.
`ifndef RPN_STACK_CALCULATOR_MACROS_SVH
`define RPN_STACK_CALCULATOR_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define RPN_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RPN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/rpn_pkg.sv -----
package rpn_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int MAX_LIST        = 16;
  localparam int LIST_KW         = $clog2(MAX_LIST);
  localparam int DATA_W          = 32;

  // command codes
  localparam logic [4:0] CMD_PUSH     = 5'd0;
  localparam logic [4:0] CMD_ADD      = 5'd1;
  localparam logic [4:0] CMD_SUB      = 5'd2;
  localparam logic [4:0] CMD_MUL      = 5'd3;
  localparam logic [4:0] CMD_DIV      = 5'd4;
  localparam logic [4:0] CMD_GT       = 5'd5;
  localparam logic [4:0] CMD_LT       = 5'd6;
  localparam logic [4:0] CMD_GE       = 5'd7;
  localparam logic [4:0] CMD_LE       = 5'd8;
  localparam logic [4:0] CMD_EQ       = 5'd9;
  localparam logic [4:0] CMD_DUP      = 5'd10;
  localparam logic [4:0] CMD_IF       = 5'd11;
  localparam logic [4:0] CMD_MODQUOT  = 5'd12;
  localparam logic [4:0] CMD_SWAP     = 5'd13;
  localparam logic [4:0] CMD_ROT      = 5'd14;
  localparam logic [4:0] CMD_ROTMINUS = 5'd15;
  localparam logic [4:0] CMD_DROP     = 5'd16;
  localparam logic [4:0] CMD_PRINT    = 5'd17;
  localparam logic [4:0] CMD_SHOW     = 5'd18;

  // result kinds
  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_PRINT = 2'd1;
  localparam logic [1:0] KIND_LIST  = 2'd2;
  localparam logic [1:0] KIND_EMPTY = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;
  localparam logic [1:0] ST_DIVZ  = 2'd3;

  // operand / result slot indexes
  localparam logic [1:0] SLOT_0 = 2'd0;
  localparam logic [1:0] SLOT_1 = 2'd1;
  localparam logic [1:0] SLOT_2 = 2'd2;

  typedef enum logic [1:0] {
    VSEL_ZERO,
    VSEL_TOP,
    VSEL_RAM
  } val_sel_t;

  typedef struct packed {
    logic [4:0]         command;
    logic signed [31:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic signed [31:0] result_value;
    logic [1:0]         status;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic       load_in;
    logic       rd_en;
    logic       cap_en;
    logic [1:0] cap_sel;
    logic       div_start;
    logic       exec;
    logic       wr_en;
    logic [1:0] wr_sel;
    logic       emit;
    logic [1:0] kind;
    logic [1:0] status;
    logic       last;
    val_sel_t   val_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic top_zero;
    logic div_done;
  } dp_stat_t;

endpackage

// ----- rtl/core/rpn_stack_calculator.sv -----
// Channel   | Ports                      | Transfer
// ----------+----------------------------+--------------------------------------
// command   | start, busy, in_data       | edge with start high and busy low
// result    | out_strobe, out_data       | each edge with out_strobe high
//
// Command timing is set by the 32-step shared divider and the single stack RAM
//   address (one read or one write a cycle); operands are read and results
//   written one stack entry at a time. Rejected commands end after the check,
//   and divide by zero is rejected once the operands are read.
// show does one RAM read per entry listed.
// Reset clears depth and control; stack contents stay undefined until pushed.
// The receiver cannot stall: every result is shown for one cycle only.
module rpn_stack_calculator #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rpn_pkg::in_item_t  in_data,
  output logic               out_strobe,
  output rpn_pkg::out_item_t out_data
);

  localparam int AW = $clog2(STACK_DEPTH);

  // control to datapath
  rpn_pkg::dp_cmd_t  dp_cmd;
  rpn_pkg::dp_stat_t dp_stat;
  logic [AW-1:0]     stack_addr;

  // sequencer: bounds checks, operand fetch, write-back, result timing
  rpn_ctrl #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_data.command),
    .busy       (busy),
    .cmd        (dp_cmd),
    .addr       (stack_addr),
    .stat       (dp_stat),
    .out_strobe (out_strobe)
  );

  // stack RAM, operand registers, ALU, divider and result register
  rpn_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (dp_cmd),
    .addr     (stack_addr),
    .in_data  (in_data),
    .stat     (dp_stat),
    .out_data (out_data)
  );

endmodule

// ----- rtl/core/rpn_ram.sv -----
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/rpn_div.sv -----
module rpn_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] dividend,
  input  logic signed [31:0] divisor,
  output logic signed [31:0] quot,
  output logic signed [31:0] rem,
  output logic               done
);

  logic        run_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [32:0] rem_r;
  logic [31:0] quo_r;
  logic [31:0] dsr_r;
  logic        negq_r;
  logic        negr_r;

  logic [32:0] shifted;
  logic [33:0] diff;

  function automatic logic [31:0] mag(input logic [31:0] x);
    mag = x[31] ? (32'd0 - x) : x;
  endfunction

  // restoring, one quotient bit per cycle
  assign shifted = {rem_r[31:0], quo_r[31]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quo_r  <= mag(dividend);
      dsr_r  <= mag(divisor);
      negq_r <= dividend[31] ^ divisor[31];
      negr_r <= dividend[31];
    end else if (run_r) begin
      if (!diff[33]) begin
        rem_r <= diff[32:0];
        quo_r <= {quo_r[30:0], 1'b1};
      end else begin
        rem_r <= shifted;
        quo_r <= {quo_r[30:0], 1'b0};
      end
    end
  end

  assign quot = negq_r ? (32'sd0 - $signed(quo_r)) : $signed(quo_r);
  assign rem  = negr_r ? (32'sd0 - $signed(rem_r[31:0])) : $signed(rem_r[31:0]);
  assign done = done_r;

endmodule

// ----- rtl/core/rpn_datapath.sv -----
module rpn_datapath #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rpn_pkg::dp_cmd_t               cmd,
  input  logic [$clog2(STACK_DEPTH)-1:0] addr,
  input  rpn_pkg::in_item_t              in_data,
  output rpn_pkg::dp_stat_t              stat,
  output rpn_pkg::out_item_t             out_data
);

  localparam int AW = $clog2(STACK_DEPTH);

  rpn_pkg::in_item_t  in_r;
  rpn_pkg::out_item_t out_r;
  logic signed [31:0] opnd_r [3];
  logic signed [31:0] res_r  [3];
  logic signed [31:0] res_nxt [3];
  logic signed [31:0] prod_r;
  logic signed [31:0] rd_data;
  logic signed [31:0] wr_data;
  logic signed [31:0] quot;
  logic signed [31:0] rem;
  logic signed [31:0] out_val;
  logic               div_done;
  logic signed [31:0] a;
  logic signed [31:0] b;
  logic signed [31:0] c;

  assign a = opnd_r[0];
  assign b = opnd_r[1];
  assign c = opnd_r[2];

  rpn_ram #(
    .WIDTH (rpn_pkg::DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (addr[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (addr[AW-1:0]),
    .rd_data (rd_data)
  );

  rpn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (b),
    .divisor  (a),
    .quot     (quot),
    .rem      (rem),
    .done     (div_done)
  );

  // product registered on its own once operands are in
  always_ff @(posedge clk) begin
    prod_r <= b * a;
  end

  always_comb begin
    res_nxt[0] = a;
    res_nxt[1] = a;
    res_nxt[2] = a;
    case (in_r.command)
      rpn_pkg::CMD_PUSH:     res_nxt[0] = in_r.push_value;
      rpn_pkg::CMD_ADD:      res_nxt[0] = b + a;
      rpn_pkg::CMD_SUB:      res_nxt[0] = b - a;
      rpn_pkg::CMD_MUL:      res_nxt[0] = prod_r;
      rpn_pkg::CMD_DIV:      res_nxt[0] = quot;
      rpn_pkg::CMD_GT:       res_nxt[0] = (b > a) ? 32'sd1 : 32'sd0;
      rpn_pkg::CMD_LT:       res_nxt[0] = (b < a) ? 32'sd1 : 32'sd0;
      rpn_pkg::CMD_GE:       res_nxt[0] = (b >= a) ? 32'sd1 : 32'sd0;
      rpn_pkg::CMD_LE:       res_nxt[0] = (b <= a) ? 32'sd1 : 32'sd0;
      rpn_pkg::CMD_EQ:       res_nxt[0] = (b == a) ? 32'sd1 : 32'sd0;
      rpn_pkg::CMD_IF:       res_nxt[0] = (a != 32'sd0) ? c : b;
      rpn_pkg::CMD_MODQUOT: begin
        res_nxt[0] = rem;
        res_nxt[1] = quot;
      end
      rpn_pkg::CMD_SWAP:     res_nxt[1] = b;
      rpn_pkg::CMD_ROT: begin
        res_nxt[1] = c;
        res_nxt[2] = b;
      end
      rpn_pkg::CMD_ROTMINUS: begin
        res_nxt[0] = b;
        res_nxt[2] = c;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      rpn_pkg::SLOT_0: wr_data = res_r[0];
      rpn_pkg::SLOT_1: wr_data = res_r[1];
      default:         wr_data = res_r[2];
    endcase
  end

  always_comb begin
    case (cmd.val_sel)
      rpn_pkg::VSEL_TOP: out_val = a;
      rpn_pkg::VSEL_RAM: out_val = rd_data;
      default:           out_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_data;
    end
    if (cmd.cap_en) begin
      case (cmd.cap_sel)
        rpn_pkg::SLOT_0: opnd_r[0] <= rd_data;
        rpn_pkg::SLOT_1: opnd_r[1] <= rd_data;
        default:         opnd_r[2] <= rd_data;
      endcase
    end
    if (cmd.exec) begin
      res_r <= res_nxt;
    end
    if (cmd.emit) begin
      out_r.result_kind  <= cmd.kind;
      out_r.result_value <= out_val;
      out_r.status       <= cmd.status;
      out_r.last         <= cmd.last;
    end
  end

  assign stat.top_zero = (a == 32'sd0);
  assign stat.div_done = div_done;
  assign out_data      = out_r;

endmodule

// ----- rtl/core/rpn_ctrl.sv -----
module rpn_ctrl #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [4:0]                     in_command,
  output logic                           busy,
  output rpn_pkg::dp_cmd_t               cmd,
  output logic [$clog2(STACK_DEPTH)-1:0] addr,
  input  rpn_pkg::dp_stat_t              stat,
  output logic                           out_strobe
);

`include "rpn_stack_calculator_macros.svh"

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int LW = $clog2(rpn_pkg::MAX_LIST + 1);
  localparam int CW = (DW > LW) ? DW : LW;
  localparam int XW = CW + 1;
  localparam int KW = rpn_pkg::LIST_KW;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_RD_ADDR,
    S_RD_CAP,
    S_OPCHK,
    S_DIV_WAIT,
    S_EXEC,
    S_WRITE,
    S_FINISH,
    S_SH_RD,
    S_SH_OUT
  } state_t;

  state_t        state_r, state_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [4:0]    cmd_r, cmd_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [1:0]    pops;
  logic [1:0]    pushes;
  logic [CW-1:0] d_ext;
  logic [CW-1:0] k_ext;
  logic [CW-1:0] n_list;
  logic [CW-1:0] rd_full;
  logic [CW-1:0] wr_full;
  logic [XW-1:0] new_depth;
  logic          is_div;
  logic          underflow;
  logic          overflow;

  always_comb begin
    case (cmd_r)
      rpn_pkg::CMD_PUSH: begin
        pops = 2'd0; pushes = 2'd1;
      end
      rpn_pkg::CMD_DUP: begin
        pops = 2'd1; pushes = 2'd2;
      end
      rpn_pkg::CMD_IF: begin
        pops = 2'd3; pushes = 2'd1;
      end
      rpn_pkg::CMD_MODQUOT, rpn_pkg::CMD_SWAP: begin
        pops = 2'd2; pushes = 2'd2;
      end
      rpn_pkg::CMD_ROT, rpn_pkg::CMD_ROTMINUS: begin
        pops = 2'd3; pushes = 2'd3;
      end
      rpn_pkg::CMD_DROP, rpn_pkg::CMD_PRINT: begin
        pops = 2'd1; pushes = 2'd0;
      end
      default: begin
        pops = 2'd2; pushes = 2'd1;
      end
    endcase
  end

  assign d_ext     = CW'(depth_r);
  assign k_ext     = CW'(k_r);
  assign n_list    = (d_ext < CW'(rpn_pkg::MAX_LIST)) ? d_ext : CW'(rpn_pkg::MAX_LIST);
  assign rd_full   = d_ext - CW'(1) - k_ext;
  assign wr_full   = d_ext - CW'(pops) + k_ext;
  assign new_depth = XW'(d_ext) - XW'(pops) + XW'(pushes);
  assign is_div    = (cmd_r == rpn_pkg::CMD_DIV) || (cmd_r == rpn_pkg::CMD_MODQUOT);
  assign underflow = d_ext < CW'(pops);
  assign overflow  = (XW'(d_ext) + XW'(pushes)) > (XW'(STACK_DEPTH) + XW'(pops));
  assign addr      = (state_r == S_WRITE) ? wr_full[AW-1:0] : rd_full[AW-1:0];

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    cmd_nxt       = cmd_r;
    depth_nxt     = depth_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    cmd.val_sel   = rpn_pkg::VSEL_ZERO;
    cmd.kind      = rpn_pkg::KIND_ACK;
    cmd.status    = rpn_pkg::ST_OK;
    cmd.last      = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load_in = 1'b1;
          cmd_nxt     = in_command;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        k_nxt = '0;
        if (cmd_r > rpn_pkg::CMD_SHOW) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end else if (cmd_r == rpn_pkg::CMD_SHOW) begin
          if (d_ext == '0) begin
            cmd.emit  = 1'b1;
            cmd.kind  = rpn_pkg::KIND_EMPTY;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_SH_RD;
          end
        end else if (underflow) begin
          cmd.emit   = 1'b1;
          cmd.status = rpn_pkg::ST_UNDER;
          state_nxt  = S_IDLE;
        end else if (overflow) begin
          cmd.emit   = 1'b1;
          cmd.status = rpn_pkg::ST_OVER;
          state_nxt  = S_IDLE;
        end else if (pops == 2'd0) begin
          state_nxt = S_EXEC;
        end else begin
          state_nxt = S_RD_ADDR;
        end
      end
      S_RD_ADDR: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_RD_CAP;
      end
      S_RD_CAP: begin
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = k_r[1:0];
        if (k_ext + CW'(1) == CW'(pops)) begin
          state_nxt = S_OPCHK;
        end else begin
          k_nxt     = k_r + KW'(1);
          state_nxt = S_RD_ADDR;
        end
      end
      S_OPCHK: begin
        if (is_div && stat.top_zero) begin
          cmd.emit   = 1'b1;
          cmd.status = rpn_pkg::ST_DIVZ;
          state_nxt  = S_IDLE;
        end else if (is_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV_WAIT;
        end else begin
          state_nxt = S_EXEC;
        end
      end
      S_DIV_WAIT: begin
        if (stat.div_done) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        k_nxt     = '0;
        state_nxt = (pushes == 2'd0) ? S_FINISH : S_WRITE;
      end
      S_WRITE: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = k_r[1:0];
        if (k_ext + CW'(1) == CW'(pushes)) begin
          state_nxt = S_FINISH;
        end else begin
          k_nxt = k_r + KW'(1);
        end
      end
      S_FINISH: begin
        depth_nxt = new_depth[DW-1:0];
        cmd.emit  = 1'b1;
        if (cmd_r == rpn_pkg::CMD_PRINT) begin
          cmd.kind    = rpn_pkg::KIND_PRINT;
          cmd.val_sel = rpn_pkg::VSEL_TOP;
        end
        state_nxt = S_IDLE;
      end
      S_SH_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_SH_OUT;
      end
      S_SH_OUT: begin
        cmd.emit    = 1'b1;
        cmd.kind    = rpn_pkg::KIND_LIST;
        cmd.val_sel = rpn_pkg::VSEL_RAM;
        cmd.last    = (k_ext + CW'(1) == n_list);
        if (k_ext + CW'(1) == n_list) begin
          state_nxt = S_IDLE;
        end else begin
          k_nxt     = k_r + KW'(1);
          state_nxt = S_SH_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      cmd_r       <= '0;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      cmd_r       <= cmd_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_valid_r;

  `RPN_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted command did not raise busy")
  `RPN_ASSERT_SAME(a_depth_range, 1'b1, depth_r <= DW'(STACK_DEPTH), "stack depth out of range")
  `RPN_ASSERT_SAME(a_depth_finish, $past(rst_n) && (depth_r != $past(depth_r)), $past(state_r == S_FINISH), "depth changed outside finish")
  `RPN_ASSERT_SAME(a_write_range, cmd.wr_en, wr_full < CW'(STACK_DEPTH), "write beyond stack")

endmodule
